// ===== rtl/llba_pkg.sv =====
// ----------------------------------------------------------------------------
// llba_pkg
// Shared types, constants and codes of the least loaded bin assigner.
// ----------------------------------------------------------------------------
package llba_pkg;

    localparam int MAX_PARTITIONS = 64;
    localparam int WEIGHT_BITS    = 16;

    localparam int AW    = $clog2(MAX_PARTITIONS);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

    localparam int TOT_W  = 31;
    localparam int WGT_W  = 16;
    localparam int PART_W = 6;

    localparam int W_EFF = (WEIGHT_BITS < WGT_W) ? WEIGHT_BITS : WGT_W;
    localparam logic [WGT_W-1:0] W_MASK = WGT_W'((64'd1 << W_EFF) - 64'd1);

    localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};
    localparam logic [31:0]      LFSR_MASK = 32'h8020_0003;

    // function codes
    localparam logic [1:0] FUNC_PLACE  = 2'd0;
    localparam logic [1:0] FUNC_CHARGE = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // placement modes
    localparam logic [1:0] MODE_LEAST  = 2'd0;
    localparam logic [1:0] MODE_RANDOM = 2'd1;
    localparam logic [1:0] MODE_ZERO   = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_PART_COUNT = 3'd0;
    localparam logic [2:0] CFG_PLACE_MODE = 3'd1;
    localparam logic [2:0] CFG_SEED       = 3'd2;
    localparam logic [2:0] CFG_LOWER      = 3'd3;
    localparam logic [2:0] CFG_UPPER      = 3'd4;

    typedef struct packed {
        logic [1:0]        func;
        logic [WGT_W-1:0]  item_weight;
        logic [PART_W-1:0] fixed_partition;
    } in_word_t;

    typedef struct packed {
        logic [PART_W-1:0] assigned_partition;
        logic [TOT_W-1:0]  partition_total;
        logic              all_balanced;
    } out_word_t;

    typedef struct packed {
        logic             clr;
        logic             wr_en;
        logic [AW-1:0]    wr_addr;
        logic [TOT_W-1:0] wr_data;
        logic             rd_en;
        logic [AW-1:0]    rd_addr;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_UPD,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/least_loaded_bin_assigner.sv =====
// ----------------------------------------------------------------------------
// least_loaded_bin_assigner
// Keeps a running total per partition and places weighted words greedily.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_data  (func, weight, partition)
//  out     | output    | out_valid/out_stall| out_data (partition, total, balance)
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One memory read per cycle over the n used totals (n being the partition
// count in use) finds the minimum in least mode, or the chosen total
// otherwise, and checks the bounds; then the update state writes the new
// total. Random placement first runs the bit-serial remainder. Reset clears
// all totals through their valid bits at once; no sweep is needed. The next
// word is taken while a result still waits under out_stall.
// ----------------------------------------------------------------------------
module least_loaded_bin_assigner (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  llba_pkg::in_word_t    in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output llba_pkg::out_word_t   out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import llba_pkg::*;

    state_t state_reg, state_next;

    logic [6:0]       part_cnt_reg;
    logic [1:0]       mode_reg;
    logic [31:0]      seed_reg;
    logic [TOT_W-1:0] lo_reg, hi_reg;

    logic [31:0]      lfsr_reg, lfsr_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [AW-1:0]    p_reg, p_next;
    logic [WGT_W-1:0] w_reg, w_next;
    logic             seek_reg, seek_next;
    logic             bad_o_reg, bad_o_next;
    logic             bad_b_reg, bad_b_next;
    logic [TOT_W-1:0] best_reg, best_next;
    logic [TOT_W-1:0] res_tot_reg, res_tot_next;
    logic             res_bal_reg, res_bal_next;
    logic             out_valid_reg, out_valid_next;
    out_word_t        out_data_reg, out_data_next;

    logic             accept;
    logic             out_free;
    logic [CNT_W-1:0] used_n;
    logic [31:0]      lfsr_step;
    logic             rem_start;
    logic             rem_done;
    logic [CNT_W-1:0] rem_val;
    mem_req_t         mem_req;
    logic [TOT_W-1:0] rd_data;

    logic [AW-1:0]    scan_idx;
    logic             scan_bad;
    logic [31:0]      sum;
    logic [TOT_W-1:0] new_tot;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (32'(part_cnt_reg) < 32'd2)
        begin
            used_n = CNT_W'(2);
        end
        else if (32'(part_cnt_reg) > MAX_PARTITIONS)
        begin
            used_n = CNT_W'(MAX_PARTITIONS);
        end
        else
        begin
            used_n = CNT_W'(part_cnt_reg);
        end
    end

    assign lfsr_step = lfsr_reg[0] ? ({1'b0, lfsr_reg[31:1]} ^ LFSR_MASK)
                                   : {1'b0, lfsr_reg[31:1]};

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_cnt_reg <= 7'd2;
            mode_reg     <= MODE_LEAST;
            seed_reg     <= 32'd1;
            lo_reg       <= '0;
            hi_reg       <= TOTAL_MAX;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PART_COUNT: part_cnt_reg <= cfg_data[6:0];
                CFG_PLACE_MODE: mode_reg     <= cfg_data[1:0];
                CFG_SEED:       seed_reg     <= cfg_data;
                CFG_LOWER:      lo_reg       <= cfg_data[TOT_W-1:0];
                CFG_UPPER:      hi_reg       <= cfg_data[TOT_W-1:0];
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.func == FUNC_PLACE && mode_reg == MODE_RANDOM)
                    begin
                        state_next = ST_MOD;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_MOD:
            begin
                if (rem_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (k_reg == n_reg)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs; in idle the input is never stalled
    always_comb
    begin
        in_stall       = 1'b1;
        rem_start      = 1'b0;
        mem_req        = '0;
        mem_req.rd_addr = k_reg[AW-1:0];
        mem_req.wr_addr = p_reg;
        mem_req.wr_data = new_tot;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                mem_req.clr = in_valid && in_data.func == FUNC_CLEAR;
                rem_start   = in_valid && in_data.func == FUNC_PLACE
                              && mode_reg == MODE_RANDOM;
            end
            ST_SCAN:
            begin
                mem_req.rd_en = k_reg < n_reg;
            end
            ST_UPD:
            begin
                mem_req.wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    // saturating update of the chosen total
    assign sum     = {1'b0, best_reg} + {{(32 - WGT_W){1'b0}}, w_reg};
    assign new_tot = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOT_W-1:0];

    assign scan_idx = AW'(k_reg - CNT_W'(1));
    assign scan_bad = (rd_data < lo_reg) || (rd_data > hi_reg);

    // datapath
    always_comb
    begin
        lfsr_next      = lfsr_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        w_next         = w_reg;
        seek_next      = seek_reg;
        bad_o_next     = bad_o_reg;
        bad_b_next     = bad_b_reg;
        best_next      = best_reg;
        res_tot_next   = res_tot_reg;
        res_bal_next   = res_bal_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = used_n;
                    k_next     = '0;
                    bad_o_next = 1'b0;
                    bad_b_next = 1'b0;
                    best_next  = '0;
                    p_next     = '0;
                    seek_next  = in_data.func == FUNC_PLACE
                                 && mode_reg != MODE_RANDOM && mode_reg != MODE_ZERO;
                    if (in_data.func == FUNC_PLACE || in_data.func == FUNC_CHARGE)
                    begin
                        w_next = in_data.item_weight & W_MASK;
                    end
                    else
                    begin
                        w_next = '0;
                    end
                    if (in_data.func == FUNC_CHARGE)
                    begin
                        if (32'(in_data.fixed_partition) < 32'(used_n))
                        begin
                            p_next = AW'(in_data.fixed_partition);
                        end
                        else
                        begin
                            p_next = AW'(used_n - CNT_W'(1));
                        end
                    end
                    if (in_data.func == FUNC_CLEAR)
                    begin
                        lfsr_next = (seed_reg != 32'd0) ? seed_reg : 32'd1;
                    end
                    else if (in_data.func == FUNC_PLACE && mode_reg == MODE_RANDOM)
                    begin
                        lfsr_next = lfsr_step;
                    end
                end
            end
            ST_MOD:
            begin
                if (rem_done)
                begin
                    p_next = AW'(rem_val);
                end
            end
            ST_SCAN:
            begin
                k_next = k_reg + CNT_W'(1);
                if (k_reg != '0)
                begin
                    if (seek_reg)
                    begin
                        // lowest total, ties kept at the lower index
                        if (scan_idx == '0 || rd_data < best_reg)
                        begin
                            bad_o_next = bad_o_reg || bad_b_reg;
                            bad_b_next = scan_bad;
                            best_next  = rd_data;
                            p_next     = scan_idx;
                        end
                        else
                        begin
                            bad_o_next = bad_o_reg || scan_bad;
                        end
                    end
                    else if (scan_idx == p_reg)
                    begin
                        best_next = rd_data;
                    end
                    else
                    begin
                        bad_o_next = bad_o_reg || scan_bad;
                    end
                end
            end
            ST_UPD:
            begin
                res_tot_next = new_tot;
                res_bal_next = !bad_o_reg && !(new_tot < lo_reg) && !(new_tot > hi_reg);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                   = 1'b1;
                    out_data_next.assigned_partition = PART_W'(p_reg);
                    out_data_next.partition_total    = res_tot_reg;
                    out_data_next.all_balanced       = res_bal_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lfsr_reg      <= 32'd1;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        p_reg        <= p_next;
        w_reg        <= w_next;
        seek_reg     <= seek_next;
        bad_o_reg    <= bad_o_next;
        bad_b_reg    <= bad_b_next;
        best_reg     <= best_next;
        res_tot_reg  <= res_tot_next;
        res_bal_reg  <= res_bal_next;
        out_data_reg <= out_data_next;
    end

    llba_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (lfsr_step),
        .divisor  (used_n),
        .done     (rem_done),
        .rem      (rem_val)
    );

    llba_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/llba_mem.sv =====
// ----------------------------------------------------------------------------
// llba_mem
// Partition total store with one valid bit per entry; invalid reads as zero.
// ----------------------------------------------------------------------------
module llba_mem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  llba_pkg::mem_req_t          req,
    output logic [llba_pkg::TOT_W-1:0]  rd_data
);
    import llba_pkg::*;

    logic [TOT_W-1:0]          mem [MAX_PARTITIONS];
    logic [MAX_PARTITIONS-1:0] vld_reg;
    logic [TOT_W-1:0]          data_q_reg;
    logic                      vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            data_q_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (req.clr)
            begin
                vld_reg <= '0;
            end
            else if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                vld_q_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = vld_q_reg ? data_q_reg : '0;

endmodule

// ===== rtl/llba_rem.sv =====
// ----------------------------------------------------------------------------
// llba_rem
// Bit-serial remainder of a 32-bit value by the partition count.
// ----------------------------------------------------------------------------
module llba_rem (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [31:0]                 dividend,
    input  logic [llba_pkg::CNT_W-1:0]  divisor,
    output logic                        done,
    output logic [llba_pkg::CNT_W-1:0]  rem
);
    import llba_pkg::*;

    logic [31:0]      dvd_reg, dvd_next;
    logic [CNT_W-1:0] div_reg, div_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[31]};
        if (start)
        begin
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle, restoring form
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = CNT_W'(trial);
            end
            dvd_next = {dvd_reg[30:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ===== test/tb_least_loaded_bin_assigner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_least_loaded_bin_assigner
// Self-checking bench for the least loaded bin assigner. A directed table walks
// the placement modes, functions and corner cases. A few words then push the
// bounds to their extremes. Random phases then reconfigure the block and
// stream random words under random idling. Every output word is compared
// with a typed table result or a bench-side model of the totals and the LFSR.
// ----------------------------------------------------------------------------
module tb_least_loaded_bin_assigner;

    import llba_pkg::*;

    localparam int         CYCLE_LIMIT  = 1_500_000;
    localparam int         PHASES       = 16;
    localparam int         PHASE_WORDS  = 50;
    localparam logic [1:0] FUNC_NOP     = 2'd3;
    localparam logic [1:0] MODE_SPARE   = 2'd3;

    typedef struct packed {
        logic        is_reg;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        in_word_t    word;
        logic        typed;
        out_word_t   result;
    } stim_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_data;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // bench copy of the block's state and registers
    logic [TOT_W-1:0] bin_total [MAX_PARTITIONS];
    logic [31:0]      lfsr_state;
    logic [6:0]       cfg_count;
    logic [1:0]       cfg_mode;
    logic [31:0]      cfg_seed;
    logic [TOT_W-1:0] cfg_lower;
    logic [TOT_W-1:0] cfg_upper;

    out_word_t expected_assignments [$];
    out_word_t next_assignment;
    stim_row_t stim_rows [$];

    logic idle_on;
    int   hold_len;
    int   cycle_count;
    int   words_sent;
    int   words_checked;
    int   reg_writes;
    int   mismatches;

    least_loaded_bin_assigner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic out_word_t predict_assignment(input in_word_t word);
        int          n;
        int          p;
        int          k;
        logic [31:0] wt;
        logic [31:0] sum;
        out_word_t   r;
        n  = (cfg_count < 2) ? 2 : (cfg_count > MAX_PARTITIONS) ? MAX_PARTITIONS
                                                                 : int'(cfg_count);
        wt = 32'(word.item_weight & W_MASK);
        p  = 0;
        case (word.func) inside
            FUNC_CLEAR:
            begin
                for (k = 0; k < MAX_PARTITIONS; k++) bin_total[k] = '0;
                lfsr_state = (cfg_seed != 32'd0) ? cfg_seed : 32'd1;
            end
            FUNC_CHARGE, FUNC_PLACE:
            begin
                if (word.func == FUNC_CHARGE)
                    p = (int'(word.fixed_partition) < n) ? int'(word.fixed_partition) : n - 1;
                else if (cfg_mode == MODE_RANDOM)
                begin
                    lfsr_state = {1'b0, lfsr_state[31:1]} ^ (lfsr_state[0] ? LFSR_MASK : 32'd0);
                    p = int'(lfsr_state % 32'(n));
                end
                else if (cfg_mode == MODE_ZERO)
                    p = 0;
                else
                begin
                    // ties stay with the lowest index
                    for (k = 1; k < n; k++)
                        if (bin_total[k] < bin_total[p]) p = k;
                end
                sum = {1'b0, bin_total[p]} + wt;
                bin_total[p] = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOT_W-1:0];
            end
            default: ;
        endcase
        r.assigned_partition = PART_W'(p);
        r.partition_total    = bin_total[p];
        r.all_balanced       = 1'b1;
        for (k = 0; k < n; k++)
            if (bin_total[k] < cfg_lower || bin_total[k] > cfg_upper) r.all_balanced = 1'b0;
        return r;
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_assignments.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (index)
            CFG_PART_COUNT: cfg_count = value[6:0];
            CFG_PLACE_MODE: cfg_mode  = value[1:0];
            CFG_SEED:       cfg_seed  = value;
            CFG_LOWER:      cfg_lower = value[TOT_W-1:0];
            CFG_UPPER:      cfg_upper = value[TOT_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic offer_word(input in_word_t word, input logic typed,
                              input out_word_t typed_result);
        int        gap;
        out_word_t predicted;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= word;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = predict_assignment(word);
        expected_assignments.push_back(typed ? typed_result : predicted);
        words_sent++;
    endtask

    function automatic void add_reg(input logic [2:0] index, input logic [31:0] value);
        stim_row_t row;
        row           = '0;
        row.is_reg    = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_word(input logic [1:0] func, input logic [15:0] wt,
                                     input logic [5:0] fp, input logic typed,
                                     input logic [5:0] part, input logic [30:0] total,
                                     input logic bal);
        stim_row_t row;
        row                           = '0;
        row.word.func                 = func;
        row.word.item_weight          = wt;
        row.word.fixed_partition      = fp;
        row.typed                     = typed;
        row.result.assigned_partition = part;
        row.result.partition_total    = total;
        row.result.all_balanced       = bal;
        stim_rows.push_back(row);
    endfunction

    // output side: per word a random hold-off, or one long hold when asked
    initial
    begin
        int stall_len;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_len > 0)
            begin
                stall_len = hold_len;
                hold_len  = 0;
            end
            else
                stall_len = idle_on ? $urandom_range(0, 14) : 0;
            if (stall_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // sampled on the falling edge ahead of the edge that takes the word
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_assignments.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: partition %0d total %0d balanced %0b",
                             out_data.assigned_partition, out_data.partition_total,
                             out_data.all_balanced);
            end
            else
            begin
                next_assignment = expected_assignments.pop_front();
                words_checked++;
                if (out_data.assigned_partition !== next_assignment.assigned_partition ||
                    out_data.partition_total    !== next_assignment.partition_total ||
                    out_data.all_balanced       !== next_assignment.all_balanced)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at word %0d: exp p=%0d t=%0d b=%0b, got p=%0d t=%0d b=%0b",
                                 words_checked, next_assignment.assigned_partition,
                                 next_assignment.partition_total, next_assignment.all_balanced,
                                 out_data.assigned_partition, out_data.partition_total,
                                 out_data.all_balanced);
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_least_loaded_bin_assigner: errors");
        $finish;
    end

    initial
    begin
        in_word_t    word;
        out_word_t   no_result;
        int          i;
        int          ph;
        logic [6:0]  count;
        logic [30:0] lo;
        logic [30:0] hi;
        int          pick;

        rst_n     = 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        idle_on   = 1'b1;
        hold_len  = 0;
        words_sent    = 0;
        words_checked = 0;
        reg_writes    = 0;
        mismatches    = 0;
        no_result     = '0;
        for (i = 0; i < MAX_PARTITIONS; i++) bin_total[i] = '0;
        lfsr_state = 32'd1;
        cfg_count  = 7'd2;
        cfg_mode   = MODE_LEAST;
        cfg_seed   = 32'd1;
        cfg_lower  = '0;
        cfg_upper  = TOTAL_MAX;

        // directed table, starting from reset settings
        add_word(FUNC_PLACE,  16'h0000, 6'd0,  1, 6'd0, 31'd0,     1);
        add_word(FUNC_PLACE,  16'hFFFF, 6'd63, 1, 6'd0, 31'd65535, 1);
        add_word(FUNC_PLACE,  16'h0005, 6'd0,  1, 6'd1, 31'd5,     1);
        add_word(FUNC_CHARGE, 16'h000A, 6'd63, 1, 6'd1, 31'd15,    1);
        add_word(FUNC_NOP,    16'hFFFF, 6'd63, 1, 6'd0, 31'd65535, 1);
        add_word(FUNC_CLEAR,  16'hFFFF, 6'd63, 1, 6'd0, 31'd0,     1);
        add_reg(CFG_LOWER, 32'd1);
        add_word(FUNC_PLACE,  16'h0000, 6'd0,  1, 6'd0, 31'd0,     0);
        // lower above upper
        add_reg(CFG_UPPER, 32'd0);
        add_word(FUNC_CHARGE, 16'h0007, 6'd1,  1, 6'd1, 31'd7,     0);
        add_reg(CFG_LOWER, 32'd0);
        add_reg(CFG_UPPER, 32'hFFFF_FFFF);
        // count below and above range
        add_reg(CFG_PART_COUNT, 32'd0);
        add_word(FUNC_CHARGE, 16'h0003, 6'd2,  0, 6'd0, 31'd0, 0);
        add_reg(CFG_PART_COUNT, 32'd1);
        add_word(FUNC_PLACE,  16'h0001, 6'd0,  0, 6'd0, 31'd0, 0);
        add_reg(CFG_PART_COUNT, 32'd100);
        add_word(FUNC_CHARGE, 16'hAAAA, 6'd63, 0, 6'd0, 31'd0, 0);
        add_word(FUNC_CHARGE, 16'h5555, 6'd21, 0, 6'd0, 31'd0, 0);
        add_word(FUNC_PLACE,  16'h0001, 6'd42, 0, 6'd0, 31'd0, 0);
        add_reg(CFG_PLACE_MODE, {30'd0, MODE_SPARE});
        add_word(FUNC_PLACE,  16'h0002, 6'd0,  0, 6'd0, 31'd0, 0);
        // zero seed loads one
        add_reg(CFG_PLACE_MODE, {30'd0, MODE_RANDOM});
        add_reg(CFG_SEED, 32'd0);
        add_word(FUNC_CLEAR,  16'h0000, 6'd0,  1, 6'd0, 31'd0, 1);
        add_word(FUNC_PLACE,  16'h0009, 6'd0,  0, 6'd0, 31'd0, 0);
        add_word(FUNC_PLACE,  16'h0009, 6'd0,  0, 6'd0, 31'd0, 0);
        add_word(FUNC_PLACE,  16'h0009, 6'd0,  0, 6'd0, 31'd0, 0);
        add_reg(CFG_PART_COUNT, 32'd3);
        add_reg(CFG_SEED, 32'hFFFF_FFFF);
        add_word(FUNC_CLEAR,  16'h1234, 6'd5,  0, 6'd0, 31'd0, 0);
        add_word(FUNC_PLACE,  16'h00FF, 6'd0,  0, 6'd0, 31'd0, 0);
        add_word(FUNC_PLACE,  16'hFF00, 6'd0,  0, 6'd0, 31'd0, 0);
        add_reg(CFG_PLACE_MODE, {30'd0, MODE_ZERO});
        add_word(FUNC_PLACE,  16'd100,  6'd2,  0, 6'd0, 31'd0, 0);
        add_word(FUNC_CHARGE, 16'h0000, 6'd2,  0, 6'd0, 31'd0, 0);
        add_reg(CFG_PLACE_MODE, {30'd0, MODE_LEAST});
        add_reg(CFG_PART_COUNT, 32'd2);
        add_word(FUNC_CLEAR,  16'h0000, 6'd0,  0, 6'd0, 31'd0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[r])
        begin
            if (stim_rows[r].is_reg)
                write_reg(stim_rows[r].reg_index, stim_rows[r].reg_value);
            else
                offer_word(stim_rows[r].word, stim_rows[r].typed, stim_rows[r].result);
        end

        // heavy charge on partition zero, then bounds at their extremes
        idle_on = 1'b0;
        word = '{func: FUNC_CHARGE, item_weight: 16'hFFFF, fixed_partition: 6'd0};
        offer_word(word, 1'b0, no_result);
        word.item_weight = 16'h0001;
        offer_word(word, 1'b0, no_result);
        write_reg(CFG_UPPER, {1'b0, TOTAL_MAX - 31'd1});
        word = '{func: FUNC_PLACE, item_weight: 16'h0000, fixed_partition: 6'd0};
        offer_word(word, 1'b0, no_result);
        write_reg(CFG_LOWER, {1'b0, TOTAL_MAX});
        write_reg(CFG_UPPER, {1'b1, TOTAL_MAX});
        offer_word(word, 1'b0, no_result);
        write_reg(CFG_LOWER, 32'd0);
        word.func = FUNC_CLEAR;
        offer_word(word, 1'b0, no_result);

        for (ph = 0; ph < PHASES; ph++)
        begin
            case ($urandom_range(0, 9))
                0:       count = 7'($urandom_range(0, 1));
                1:       count = 7'($urandom_range(65, 127));
                2:       count = 7'd64;
                default: count = 7'($urandom_range(2, 12));
            endcase
            write_reg(CFG_PART_COUNT, {25'($urandom), count});
            write_reg(CFG_PLACE_MODE, {30'($urandom), 2'($urandom_range(0, 3))});
            write_reg(CFG_SEED, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
            lo = ($urandom_range(0, 2) == 0) ? 31'd0 : 31'($urandom_range(0, 400000));
            case ($urandom_range(0, 2))
                0:       hi = TOTAL_MAX;
                1:       hi = lo + 31'($urandom_range(0, 3000000));
                default: hi = 31'($urandom_range(0, lo));
            endcase
            write_reg(CFG_LOWER, {1'($urandom), lo});
            write_reg(CFG_UPPER, {1'($urandom), hi});

            idle_on = ($urandom_range(0, 3) != 0);
            if (ph == 3)
            begin
                // sender keeps pushing while the output side is held off
                idle_on  = 1'b0;
                hold_len = 400;
            end

            for (i = 0; i < PHASE_WORDS; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)       word.func = FUNC_CLEAR;
                else if (pick < 8)  word.func = FUNC_NOP;
                else if (pick < 40) word.func = FUNC_CHARGE;
                else                word.func = FUNC_PLACE;
                case ($urandom_range(0, 3))
                    0:       word.item_weight = 16'($urandom_range(0, 255));
                    1:       word.item_weight = 16'hFFFF;
                    default: word.item_weight = 16'($urandom);
                endcase
                word.fixed_partition = 6'($urandom);
                offer_word(word, 1'b0, no_result);
            end
        end

        wait_drained();
        repeat (120) @(posedge clk);

        $display("run covered %0d words, %0d results checked, %0d register writes",
                 words_sent, words_checked, reg_writes);
        $display("all modes, clears, charges, bound extremes and a long output hold; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("tb_least_loaded_bin_assigner: clean");
        else
            $display("tb_least_loaded_bin_assigner: errors");
        $finish;
    end

endmodule
